@@ rtl/lfls_pkg.sv @@
// Package: shared types, codes and constants for the loop filter level search.
package lfls_pkg;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_TWO_PASS   = 2'd0;
   localparam logic [1:0] REG_INTRA      = 2'd1;
   localparam logic [1:0] REG_LARGE_TX   = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_MEASURE = 2'd0;
   localparam logic [1:0] KIND_DONE    = 2'd1;
   localparam logic [1:0] KIND_IGNORED = 2'd2;

   // Request kinds
   localparam logic REQ_START  = 1'b0;
   localparam logic REQ_REPORT = 1'b1;

   // Search direction codes
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_DOWN = 2'd1;
   localparam logic [1:0] DIR_UP   = 2'd2;

   localparam int ERR_W     = 48;
   localparam int LVL_W     = 6;
   localparam int ACC_W     = 50;
   // Divide by twenty: five 10-bit digits, reciprocal of five with a 15-bit shift
   localparam int DIV_DIGIT_W = 10;
   localparam int DIV_STEPS   = 5;
   localparam logic [12:0] DIV_RECIP = 13'd6554;
   localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_WAIT_MID, ST_WAIT_LOW, ST_WAIT_HIGH, ST_TOP, ST_SCALE, ST_DIV,
      ST_STORE, ST_LOW_CHK, ST_LOW_CMP, ST_HIGH_CHK, ST_HIGH_CMP, ST_UPDATE, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_START, OP_REPORT_MID, OP_REPORT, OP_BIAS_SHIFT, OP_BIAS_SCALE,
      OP_DIV_STEP, OP_BIAS_STORE, OP_READ, OP_CMP_LO, OP_CMP_HI, OP_UPDATE, OP_DONE
   } op_type;

   typedef enum logic [2:0] {
      SEL_ZERO, SEL_START, SEL_MID, SEL_LO, SEL_HI, SEL_BEST
   } lvl_sel_type;

   typedef struct packed {
      logic        two_pass;
      logic [9:0]  intra_rating;
      logic        large_tx;
   } cfg_type;

   typedef struct packed {
      op_type      op;
      logic        emit;
      logic [1:0]  kind;
      lvl_sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic step_zero;
      logic need_div;
      logic div_last;
      logic lo_go;
      logic lo_known;
      logic hi_go;
      logic hi_known;
   } status_type;

endpackage

@@ rtl/lfls_ctrl.sv @@
// Controller: sequencer that steps the level search and drives the datapath.
module lfls_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_kind,
   input  lfls_pkg::status_type status,
   output lfls_pkg::cmd_type  cmd,
   output logic               busy
);
   import lfls_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '{op: OP_NONE, emit: 1'b0, kind: KIND_MEASURE, sel: SEL_ZERO};
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE, ST_WAIT_MID, ST_WAIT_LOW, ST_WAIT_HIGH: begin
            busy = 1'b0;
            if (start) begin
               if (req_kind == REQ_START) begin
                  cmd      = '{op: OP_START, emit: 1'b1, kind: KIND_MEASURE, sel: SEL_START};
                  state_in = ST_WAIT_MID;
               end else if (state_ff == ST_IDLE) begin
                  cmd = '{op: OP_NONE, emit: 1'b1, kind: KIND_IGNORED, sel: SEL_ZERO};
               end else if (state_ff == ST_WAIT_MID) begin
                  cmd.op   = OP_REPORT_MID;
                  cmd.sel  = SEL_MID;
                  state_in = ST_TOP;
               end else if (state_ff == ST_WAIT_LOW) begin
                  cmd.op   = OP_REPORT;
                  cmd.sel  = SEL_LO;
                  state_in = ST_LOW_CHK;
               end else begin
                  cmd.op   = OP_REPORT;
                  cmd.sel  = SEL_HI;
                  state_in = ST_HIGH_CHK;
               end
            end
         end
         ST_TOP: begin
            if (status.step_zero) begin
               cmd.op   = OP_READ;
               cmd.sel  = SEL_BEST;
               state_in = ST_DONE;
            end else begin
               cmd.op   = OP_BIAS_SHIFT;
               state_in = status.need_div ? ST_SCALE : ST_STORE;
            end
         end
         ST_SCALE: begin
            cmd.op   = OP_BIAS_SCALE;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (status.div_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.op   = OP_BIAS_STORE;
            state_in = ST_LOW_CHK;
         end
         ST_LOW_CHK: begin
            if (!status.lo_go) begin
               state_in = ST_HIGH_CHK;
            end else if (!status.lo_known) begin
               cmd      = '{op: OP_NONE, emit: 1'b1, kind: KIND_MEASURE, sel: SEL_LO};
               state_in = ST_WAIT_LOW;
            end else begin
               cmd.op   = OP_READ;
               cmd.sel  = SEL_LO;
               state_in = ST_LOW_CMP;
            end
         end
         ST_LOW_CMP: begin
            cmd.op   = OP_CMP_LO;
            cmd.sel  = SEL_LO;
            state_in = ST_HIGH_CHK;
         end
         ST_HIGH_CHK: begin
            if (!status.hi_go) begin
               state_in = ST_UPDATE;
            end else if (!status.hi_known) begin
               cmd      = '{op: OP_NONE, emit: 1'b1, kind: KIND_MEASURE, sel: SEL_HI};
               state_in = ST_WAIT_HIGH;
            end else begin
               cmd.op   = OP_READ;
               cmd.sel  = SEL_HI;
               state_in = ST_HIGH_CMP;
            end
         end
         ST_HIGH_CMP: begin
            cmd.op   = OP_CMP_HI;
            cmd.sel  = SEL_HI;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.op   = OP_UPDATE;
            state_in = ST_TOP;
         end
         ST_DONE: begin
            cmd      = '{op: OP_DONE, emit: 1'b1, kind: KIND_DONE, sel: SEL_BEST};
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // Done result always returns the controller to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_DONE |=> state_ff == ST_IDLE)
      else $error("done did not return to idle");

   // Measure request for an unknown lower level releases busy
   a_low_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOW_CHK && status.lo_go && !status.lo_known) |=> !busy)
      else $error("lower measure request left block busy");

   // Every emitted result comes from a state that accepts a request, checks a neighbor level or finishes the search
   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!busy || state_ff == ST_DONE || state_ff == ST_LOW_CHK
                    || state_ff == ST_HIGH_CHK))
      else $error("result emitted from unexpected state");
`endif

endmodule

@@ rtl/lfls_dp.sv @@
// Datapath: search registers, error cache, bias arithmetic and result register.
module lfls_dp #(
   parameter int LEVEL_MAX = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lfls_pkg::cfg_type     cfg,
   input  lfls_pkg::cmd_type     cmd,
   input  logic [5:0]            req_start_level,
   input  logic [47:0]           req_measured_error,
   output lfls_pkg::status_type  status,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_kind_res,
   output logic [5:0]            rsp_level,
   output logic [47:0]           rsp_best_error
);
   import lfls_pkg::*;

   localparam int MaxTwoInt = (LEVEL_MAX * 3 / 4 > 63) ? 63 : LEVEL_MAX * 3 / 4;
   localparam int MaxOneInt = (LEVEL_MAX > 63) ? 63 : LEVEL_MAX;
   localparam logic [5:0] MaxTwo = 6'(MaxTwoInt);
   localparam logic [5:0] MaxOne = 6'(MaxOneInt);

   logic [ERR_W-1:0] cache_mem [64];
   logic [ERR_W-1:0] mem_q_ff;

   logic [63:0]      mask_ff;
   logic [5:0]       mid_ff, best_ff;
   logic [ERR_W-1:0] bsf_ff, bias_ff;
   logic [3:0]       step_ff;
   logic [1:0]       dir_ff;
   logic [ACC_W-1:0] acc_ff;
   logic [4:0]       rem_ff;
   logic [5:0]       div_cnt_ff;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_kind_ff;
   logic [5:0]        rsp_level_ff;
   logic [ERR_W-1:0]  rsp_err_ff;

   logic [5:0]       maxl, start_lv, lo, hi, sel_lv;
   logic [6:0]       hi_sum;
   logic [3:0]       shamt;
   logic [ERR_W-1:0] shifted;
   logic [14:0]      div_t;
   logic [25:0]      div_prod;
   logic [9:0]       div_q;
   logic [14:0]      div_r;
   logic [ERR_W:0]   lo_limit;
   logic             lo_win, hi_win;

   // Level window around the midpoint
   always_comb begin
      maxl     = (cfg.two_pass && cfg.intra_rating > 10'd8) ? MaxTwo : MaxOne;
      start_lv = (req_start_level > maxl) ? maxl : req_start_level;
      hi_sum   = {1'b0, mid_ff} + {3'b0, step_ff};
      hi       = (hi_sum > {1'b0, maxl}) ? maxl : hi_sum[5:0];
      lo       = (mid_ff >= {2'b0, step_ff}) ? mid_ff - {2'b0, step_ff} : 6'd0;
      case (cmd.sel)
         SEL_START: sel_lv = start_lv;
         SEL_MID:   sel_lv = mid_ff;
         SEL_LO:    sel_lv = lo;
         SEL_HI:    sel_lv = hi;
         SEL_BEST:  sel_lv = best_ff;
         default:   sel_lv = 6'd0;
      endcase
      shamt    = 4'd15 - {1'b0, mid_ff[5:3]};
      shifted  = bsf_ff >> shamt;
      // One digit of the divide by twenty: quarter, then reciprocal of five
      div_t    = {rem_ff, acc_ff[ACC_W-1 -: DIV_DIGIT_W]};
      div_prod = {13'd0, div_t[14:2]} * {13'd0, DIV_RECIP};
      div_q    = div_prod[24:15];
      div_r    = div_t - ({5'd0, div_q} * 15'd20);
      lo_limit = {1'b0, bsf_ff} + {1'b0, bias_ff};
      lo_win   = {1'b0, mem_q_ff} < lo_limit;
      hi_win   = (bias_ff <= bsf_ff) && (mem_q_ff < bsf_ff - bias_ff);
   end

   // Status to the controller
   always_comb begin
      status.step_zero = (step_ff == 4'd0);
      status.need_div  = cfg.two_pass && (cfg.intra_rating < 10'd20);
      status.div_last  = (div_cnt_ff == DIV_LAST);
      status.lo_go     = (dir_ff != DIR_UP) && (lo != mid_ff);
      status.lo_known  = mask_ff[lo];
      status.hi_go     = (dir_ff != DIR_DOWN) && (hi != mid_ff);
      status.hi_known  = mask_ff[hi];
   end

   // Error cache: write on report, registered read
   always_ff @(posedge clock) begin
      if (cmd.op == OP_REPORT || cmd.op == OP_REPORT_MID) begin
         cache_mem[sel_lv] <= req_measured_error;
      end
      if (cmd.op == OP_READ) begin
         mem_q_ff <= cache_mem[sel_lv];
      end
   end

   // Bias arithmetic: shift and step, rating scale, divide by twenty
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_BIAS_SHIFT: acc_ff <= ACC_W'(shifted[39:0] * step_ff);
         OP_BIAS_SCALE: begin
            acc_ff     <= ACC_W'(acc_ff[43:0] * cfg.intra_rating[4:0]);
            rem_ff     <= 5'd0;
            div_cnt_ff <= 6'd0;
         end
         OP_DIV_STEP: begin
            rem_ff     <= div_r[4:0];
            acc_ff     <= {acc_ff[ACC_W-DIV_DIGIT_W-1:0], div_q};
            div_cnt_ff <= div_cnt_ff + 6'd1;
         end
         default: begin
         end
      endcase
   end

   // Search registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         mid_ff  <= '0;
         best_ff <= '0;
         bsf_ff  <= '0;
         bias_ff <= '0;
         step_ff <= '0;
         dir_ff  <= DIR_NONE;
      end else begin
         case (cmd.op)
            OP_START: begin
               mask_ff <= '0;
               mid_ff  <= start_lv;
               best_ff <= start_lv;
               bsf_ff  <= '0;
               bias_ff <= '0;
               step_ff <= (start_lv < 6'd16) ? 4'd4 : start_lv[5:2];
               dir_ff  <= DIR_NONE;
            end
            OP_REPORT_MID: begin
               mask_ff[sel_lv] <= 1'b1;
               bsf_ff          <= req_measured_error;
               best_ff         <= sel_lv;
            end
            OP_REPORT: mask_ff[sel_lv] <= 1'b1;
            OP_BIAS_STORE: begin
               bias_ff <= cfg.large_tx ? acc_ff[ERR_W:1] : acc_ff[ERR_W-1:0];
            end
            OP_CMP_LO: begin
               if (lo_win) begin
                  best_ff <= lo;
                  if (mem_q_ff < bsf_ff) begin
                     bsf_ff <= mem_q_ff;
                  end
               end
            end
            OP_CMP_HI: begin
               if (hi_win) begin
                  best_ff <= hi;
                  bsf_ff  <= mem_q_ff;
               end
            end
            OP_UPDATE: begin
               if (best_ff == mid_ff) begin
                  step_ff <= {1'b0, step_ff[3:1]};
                  dir_ff  <= DIR_NONE;
               end else begin
                  dir_ff <= (best_ff < mid_ff) ? DIR_DOWN : DIR_UP;
                  mid_ff <= best_ff;
               end
            end
            OP_DONE: bsf_ff <= mem_q_ff;
            default: begin
            end
         endcase
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      rsp_kind_ff  <= cmd.kind;
      rsp_level_ff <= sel_lv;
      rsp_err_ff   <= (cmd.op == OP_DONE) ? mem_q_ff : '0;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind_res   = rsp_kind_ff;
   assign rsp_level      = rsp_level_ff;
   assign rsp_best_error = rsp_err_ff;

`ifndef SYNTHESIS
   // Higher level never raises the best error
   a_hi_drop: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_CMP_HI |=> bsf_ff <= $past(bsf_ff))
      else $error("higher level raised best error");

   // Measure requests carry no error
   a_meas_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_MEASURE) |-> rsp_err_ff == '0)
      else $error("measure request with nonzero error");

   // Update moves the midpoint or halves the step
   a_update: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_UPDATE |=> (mid_ff != $past(mid_ff)) || (step_ff < $past(step_ff))
                              || ($past(step_ff) == 4'd0))
      else $error("update made no progress");
`endif

endmodule

@@ rtl/loop_filter_level_search_top.sv @@
// Top level: loop filter level search with configuration registers.
//
// A start request (kind 0) answers in the next cycle with the clamped level to
// measure; a report (kind 1) is taken while busy is low and the next measure
// request or the done result follows after the sequencer walks the search: each
// search step forms the bias by shift, step multiply and store (two-pass mode
// with intra rating below 20 adds a rating scale and a divide by twenty taken
// as five 10-bit digits, one reciprocal multiply per digit), checks each
// neighbor level and compares it when it is already in the error cache (one
// cache read port), then updates; the done result needs a cache read and a
// done state. A result shows in the cycle after the state that issues it. The
// rsp_valid strobe lasts one cycle and cannot be held off, so capture it when
// it rises. A report while idle gives kind 2 and changes nothing.
module loop_filter_level_search_top #(
   parameter int LEVEL_MAX = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [5:0]  req_start_level,
   input  logic [47:0] req_measured_error,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind_res,
   output logic [5:0]  rsp_level,
   output logic [47:0] rsp_best_error,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import lfls_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;
   logic       wr_en;

   // Configuration register writes
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         unique case (paddr[3:2])
            REG_TWO_PASS: cfg_ff.two_pass     <= pwdata[0];
            REG_INTRA:    cfg_ff.intra_rating <= pwdata[9:0];
            REG_LARGE_TX: cfg_ff.large_tx     <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   // Register read-back
   always_comb begin
      unique case (paddr[3:2])
         REG_TWO_PASS: prdata = {31'd0, cfg_ff.two_pass};
         REG_INTRA:    prdata = {22'd0, cfg_ff.intra_rating};
         REG_LARGE_TX: prdata = {31'd0, cfg_ff.large_tx};
         default:      prdata = 32'd0;
      endcase
   end

   lfls_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   lfls_dp #(
      .LEVEL_MAX (LEVEL_MAX)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .cmd                (cmd),
      .req_start_level    (req_start_level),
      .req_measured_error (req_measured_error),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_kind_res       (rsp_kind_res),
      .rsp_level          (rsp_level),
      .rsp_best_error     (rsp_best_error)
   );

endmodule

@@ test/loop_filter_level_search_top_tb.sv @@
// Testbench: loop filter level search, predicted searches checked result by result.
`timescale 1ns / 1ps

module loop_filter_level_search_top_tb;
   import lfls_pkg::*;

   localparam int LEVEL_MAX = 63;
   localparam logic [47:0] ERR_ALL = 48'hFFFF_FFFF_FFFF;
   localparam int WATCH_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 80;

   // Search phases and walk entry points of the level search
   typedef enum int {PH_IDLE, PH_MID, PH_LOW, PH_HIGH} phase_type;
   localparam int AT_TOP  = 0;
   localparam int AT_LOW  = 1;
   localparam int AT_HIGH = 2;

   typedef struct {
      logic [1:0]  kind;
      logic [5:0]  level;
      logic [47:0] err;
   } search_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_kind = 1'b0;
   logic [5:0]  req_start_level = '0;
   logic [47:0] req_measured_error = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_kind_res;
   logic [5:0]  rsp_level;
   logic [47:0] rsp_best_error;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   loop_filter_level_search_top #(.LEVEL_MAX(LEVEL_MAX)) dut (.*);

   always #5 clock = ~clock;

   // Predicted search state and configuration
   cfg_type      cfg;
   logic [47:0]  err_cache [64];
   logic [63:0]  known;
   int           mid_lvl, best_lvl, step, dir;
   logic [63:0]  best_cost, bias;
   phase_type    phase;

   search_rsp_type pending_q[$];
   search_rsp_type last_rsp;
   int  fail_cnt = 0;
   int  item_cnt = 0, rsp_cnt = 0, done_cnt = 0, search_cnt = 0, cfg_cnt = 0;
   bit  idling = 1'b1;
   int  watch = 0;

   // Error profile for the current search
   int          opt_lvl;
   logic [63:0] base_err, slope;

   function automatic int top_level();
      int m;
      m = LEVEL_MAX;
      if (cfg.two_pass && cfg.intra_rating > 8) m = LEVEL_MAX * 3 / 4;
      if (m > 63) m = 63;
      return m;
   endfunction

   function automatic search_rsp_type mk(logic [1:0] k, int lv, logic [47:0] e);
      search_rsp_type r;
      r.kind = k;
      r.level = lv[5:0];
      r.err = e;
      return r;
   endfunction

   // Walk the search from the given entry point until a measure or done result
   function automatic search_rsp_type walk(int entry);
      int maxl, hi, lo;
      logic [63:0] b, e;
      maxl = top_level();
      while (1) begin
         hi = mid_lvl + step;
         lo = (mid_lvl >= step) ? mid_lvl - step : 0;
         if (hi > maxl) hi = maxl;
         if (entry == AT_TOP) begin
            if (step == 0) begin
               best_cost = {16'b0, err_cache[best_lvl]};
               phase = PH_IDLE;
               return mk(KIND_DONE, best_lvl, best_cost[47:0]);
            end
            b = (best_cost >> (15 - mid_lvl / 8)) * step;
            if (cfg.two_pass && cfg.intra_rating < 20) b = (b * cfg.intra_rating) / 20;
            if (cfg.large_tx) b = b >> 1;
            bias = {16'b0, b[47:0]};
            entry = AT_LOW;
         end
         if (entry == AT_LOW) begin
            if (dir <= 0 && lo != mid_lvl) begin
               if (!known[lo]) begin
                  phase = PH_LOW;
                  return mk(KIND_MEASURE, lo, '0);
               end
               e = {16'b0, err_cache[lo]};
               if (e < best_cost + bias) begin
                  if (e < best_cost) best_cost = e;
                  best_lvl = lo;
               end
            end
            entry = AT_HIGH;
         end
         if (dir >= 0 && hi != mid_lvl) begin
            if (!known[hi]) begin
               phase = PH_HIGH;
               return mk(KIND_MEASURE, hi, '0);
            end
            e = {16'b0, err_cache[hi]};
            if (bias <= best_cost && e < best_cost - bias) begin
               best_cost = e;
               best_lvl = hi;
            end
         end
         if (best_lvl == mid_lvl) begin
            step = step / 2;
            dir = 0;
         end else begin
            dir = (best_lvl < mid_lvl) ? -1 : 1;
            mid_lvl = best_lvl;
         end
         entry = AT_TOP;
      end
   endfunction

   function automatic search_rsp_type predict_search(logic k, logic [5:0] sl, logic [47:0] me);
      int lv, entry;
      if (k == REQ_START) begin
         lv = sl;
         if (lv > top_level()) lv = top_level();
         known = '0;
         mid_lvl = lv;
         best_lvl = lv;
         best_cost = '0;
         bias = '0;
         step = (lv < 16) ? 4 : lv / 4;
         dir = 0;
         phase = PH_MID;
         return mk(KIND_MEASURE, lv, '0);
      end
      if (phase == PH_IDLE) return mk(KIND_IGNORED, 0, '0);
      if (phase == PH_MID) begin
         lv = mid_lvl;
         entry = AT_TOP;
      end else if (phase == PH_LOW) begin
         lv = (mid_lvl >= step) ? mid_lvl - step : 0;
         entry = AT_LOW;
      end else begin
         lv = mid_lvl + step;
         if (lv > top_level()) lv = top_level();
         entry = AT_HIGH;
      end
      err_cache[lv] = me;
      known[lv] = 1'b1;
      if (phase == PH_MID) begin
         best_cost = {16'b0, me};
         best_lvl = lv;
      end
      return walk(entry);
   endfunction

   // Check each result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         search_rsp_type x;
         rsp_cnt++;
         if (pending_q.size() == 0) begin
            $error("unexpected result kind=%0d level=%0d", rsp_kind_res, rsp_level);
            fail_cnt++;
         end else begin
            x = pending_q.pop_front();
            if (rsp_kind_res !== x.kind) begin
               $error("kind_res: expected %0d, actual %0d", x.kind, rsp_kind_res);
               fail_cnt++;
            end
            if (rsp_level !== x.level) begin
               $error("level: expected %0d, actual %0d", x.level, rsp_level);
               fail_cnt++;
            end
            if (rsp_best_error !== x.err) begin
               $error("best_error: expected %0h, actual %0h", x.err, rsp_best_error);
               fail_cnt++;
            end
         end
      end
   end

   // Watchdog: count cycles with no request, result or register write
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (psel && penable) || reset) watch <= 0;
      else watch <= watch + 1;
      if (watch > WATCH_LIMIT) begin
         $display("watchdog expired with %0d results pending", pending_q.size());
         $display("loop_filter_level_search_top test failed");
         $finish;
      end
   end

   // Send one request, holding start until accepted
   task automatic send_request(logic k, logic [5:0] sl, logic [47:0] me);
      if (idling && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= k;
      req_start_level <= sl;
      req_measured_error <= me;
      do @(posedge clock); while (busy);
      last_rsp = predict_search(k, sl, me);
      pending_q.push_back(last_rsp);
      item_cnt++;
   endtask

   // Hold off until every predicted result has come and the block is idle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      drain();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_TWO_PASS: cfg.two_pass = value[0];
         REG_INTRA:    cfg.intra_rating = value[9:0];
         REG_LARGE_TX: cfg.large_tx = value[0];
         default: ;
      endcase
      cfg_cnt++;
   endtask

   // Write all three registers, with junk in the unused upper bits
   task automatic set_config(logic tp, logic [9:0] ir, logic lt);
      write_reg(REG_TWO_PASS, {31'($urandom_range(0, 32'h7FFF_FFFF)), tp});
      write_reg(REG_INTRA, {22'($urandom_range(0, 32'h3F_FFFF)), ir});
      write_reg(REG_LARGE_TX, {31'($urandom_range(0, 32'h7FFF_FFFF)), lt});
   endtask

   function automatic logic [47:0] rand_err();
      return {16'($urandom), $urandom};
   endfunction

   // Error of a level under the current profile
   function automatic logic [47:0] level_err(int lv, int profile);
      logic [63:0] v;
      case (profile)
         0: return rand_err();
         1: begin
            v = base_err + slope * (lv - opt_lvl) * (lv - opt_lvl);
            return (v > ERR_ALL) ? ERR_ALL : v[47:0];
         end
         2: return base_err[47:0];
         3: return 48'($urandom_range(0, 255));
         default: return ERR_ALL - 48'($urandom_range(0, 3));
      endcase
   endfunction

   // One search: start, then answer each measure request; noise restarts or abandons
   task automatic run_search(logic [5:0] sl, int profile, bit noise);
      int n;
      opt_lvl = $urandom_range(0, 63);
      base_err = {$urandom_range(0, 65535), $urandom} >> $urandom_range(0, 40);
      slope = 64'($urandom) >> $urandom_range(0, 31);
      search_cnt++;
      send_request(REQ_START, sl, rand_err());
      n = 0;
      while (phase != PH_IDLE && n < 200) begin
         if (noise && $urandom_range(0, 59) == 0)
            send_request(REQ_START, 6'($urandom_range(0, 63)), rand_err());
         else if (noise && $urandom_range(0, 79) == 0)
            break;
         else
            send_request(REQ_REPORT, 6'($urandom_range(0, 63)),
                         level_err(last_rsp.level, profile));
         n++;
      end
      if (last_rsp.kind == KIND_DONE) done_cnt++;
   endtask

   task automatic test_idle_report();
      send_request(REQ_REPORT, 6'd63, ERR_ALL);
      send_request(REQ_REPORT, 6'd0, '0);
   endtask

   task automatic test_directed();
      run_search(6'd63, 4, 1'b0);
      run_search(6'd0, 3, 1'b0);
      run_search(6'd15, 2, 1'b0);
      // restart in the middle of a search
      send_request(REQ_START, 6'd16, '0);
      send_request(REQ_REPORT, 6'd0, 48'd1000);
      run_search(6'd16, 1, 1'b0);
      set_config(1'b1, 10'd9, 1'b0);
      run_search(6'd63, 1, 1'b0);
      set_config(1'b1, 10'd19, 1'b1);
      run_search(6'd40, 1, 1'b0);
   endtask

   task automatic test_random(int target);
      int goal;
      goal = item_cnt + target;
      while (item_cnt < goal) begin
         run_search(6'($urandom_range(0, 63)), $urandom_range(0, 4), 1'b1);
         if ($urandom_range(0, 15) == 0)
            send_request(REQ_REPORT, 6'($urandom_range(0, 63)), rand_err());
      end
   endtask

   task automatic test_configs();
      set_config(1'b0, 10'd0, 1'b0);
      test_random(200);
      set_config(1'b1, 10'd1023, 1'b0);
      test_random(180);
      set_config(1'b1, 10'd0, 1'b1);
      test_random(180);
      set_config(1'b1, 10'd19, 1'b0);
      test_random(180);
      set_config(1'b0, 10'd700, 1'b1);
      test_random(180);
      set_config(1'b1, 10'd8, 1'b1);
      test_random(180);
      set_config(1'b1, 10'd20, 1'b0);
      test_random(100);
   endtask

   // Let every result come before the final stretch
   task automatic test_pause_and_tail();
      drain();
      idling = 1'b0;
      set_config(1'b1, 10'($urandom_range(0, 19)), 1'b1);
      test_random(150);
   endtask

   initial begin
      cfg = '0;
      known = '0;
      mid_lvl = 0;
      best_lvl = 0;
      step = 0;
      dir = 0;
      best_cost = '0;
      bias = '0;
      phase = PH_IDLE;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_report();
      test_directed();
      test_configs();
      test_pause_and_tail();
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests, %0d results, %0d searches (%0d finished), %0d writes",
               item_cnt, rsp_cnt, search_cnt, done_cnt, cfg_cnt);
      if (fail_cnt == 0)
         $display("loop_filter_level_search_top test passed");
      else
         $display("loop_filter_level_search_top test failed");
      $finish;
   end

endmodule
